// File: rtl/core/scf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scf_pkg;

    localparam int unsigned MaxStrips = 2048;
    localparam int unsigned StripW    = 12;
    localparam int unsigned SampleW   = 13;
    localparam int unsigned SumW      = 15;
    localparam int unsigned SizeW     = 12;
    localparam int unsigned IndexW    = 11;
    localparam int unsigned InDataW   = 56;
    localparam int unsigned OutDataW  = 80;
    localparam int unsigned FifoDepth = 8;
    localparam int unsigned FifoAw    = 3;
    localparam int unsigned FifoCntW  = 4;

    localparam logic [SizeW-1:0]    SizeCap      = (MaxStrips > 4095) ? 12'd4095
                                                                      : SizeW'(MaxStrips);
    localparam logic [IndexW-1:0]   IndexCap     = 11'd2047;
    localparam logic [SizeW-1:0]    MinSizeReset = 12'd2;
    localparam logic [StripW-1:0]   StripMax     = 12'd4095;
    localparam logic [FifoCntW-1:0] FifoRoomMax  = FifoCntW'(FifoDepth - 4);

    typedef struct packed {
        logic [StripW-1:0]         strip_id;
        logic signed [SumW-1:0]    sum;
        logic signed [SampleW-1:0] smax;
        logic                      event_end;
    } strip_t;

    typedef struct packed {
        logic [StripW-1:0]         first_strip;
        logic [SizeW-1:0]          cluster_size;
        logic [StripW-1:0]         peak_strip;
        logic signed [SumW-1:0]    peak_sum;
        logic signed [SampleW-1:0] peak_sample;
        logic                      size_ok;
        logic [IndexW-1:0]         cluster_index;
        logic                      last_cluster;
    } result_t;

    typedef struct packed {
        logic push_a;
        logic push_b;
    } push_t;

endpackage

`default_nettype wire

// File: rtl/core/scf_input_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module scf_input_stage (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               in_accept,
    input  wire logic [scf_pkg::StripW-1:0]         in_strip,
    input  wire logic signed [scf_pkg::SampleW-1:0] in_s0,
    input  wire logic signed [scf_pkg::SampleW-1:0] in_s1,
    input  wire logic signed [scf_pkg::SampleW-1:0] in_s2,
    input  wire logic                               in_end,
    output logic                                    item_valid,
    output scf_pkg::strip_t                         item
);

    logic                               valid_reg;
    scf_pkg::strip_t                    item_reg;
    scf_pkg::strip_t                    item_next;
    logic signed [scf_pkg::SampleW-1:0] smax01;

    always_comb begin
        smax01              = (in_s1 > in_s0) ? in_s1 : in_s0;
        item_next.strip_id  = in_strip;
        item_next.sum       = scf_pkg::SumW'(in_s0) + scf_pkg::SumW'(in_s1)
                            + scf_pkg::SumW'(in_s2);
        item_next.smax      = (in_s2 > smax01) ? in_s2 : smax01;
        item_next.event_end = in_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_accept;
        end
        if (in_accept) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// File: rtl/core/scf_cluster.sv
`timescale 1ns / 1ps
`default_nettype none

module scf_cluster (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_write,
    input  wire logic [scf_pkg::SizeW-1:0]    cfg_min_size,
    input  wire logic                         item_valid,
    input  wire scf_pkg::strip_t              item,
    output scf_pkg::push_t                    push,
    output scf_pkg::result_t                  res_a,
    output scf_pkg::result_t                  res_b
);

    logic [scf_pkg::SizeW-1:0]           min_size_reg;
    logic                                open_reg, open_next;
    logic [scf_pkg::StripW-1:0]          prev_reg, prev_next;
    logic [scf_pkg::StripW-1:0]          start_reg, start_next;
    logic [scf_pkg::SizeW-1:0]           run_reg, run_next;
    logic [scf_pkg::StripW-1:0]          best_strip_reg, best_strip_next;
    logic signed [scf_pkg::SumW-1:0]     best_sum_reg, best_sum_next;
    logic signed [scf_pkg::SampleW-1:0]  best_sample_reg, best_sample_next;
    logic [scf_pkg::IndexW-1:0]          count_reg, count_next;
    logic [scf_pkg::IndexW-1:0]          idx_after;
    logic                                adjacent;

    always_comb begin
        adjacent = open_reg && (prev_reg != scf_pkg::StripMax)
                && (item.strip_id == prev_reg + 12'd1);

        open_next        = open_reg;
        prev_next        = prev_reg;
        start_next       = start_reg;
        run_next         = run_reg;
        best_strip_next  = best_strip_reg;
        best_sum_next    = best_sum_reg;
        best_sample_next = best_sample_reg;
        count_next       = count_reg;
        idx_after        = count_reg;
        push             = '0;

        res_a.first_strip   = start_reg;
        res_a.cluster_size  = run_reg;
        res_a.peak_strip    = best_strip_reg;
        res_a.peak_sum      = best_sum_reg;
        res_a.peak_sample   = best_sample_reg;
        res_a.size_ok       = (run_reg >= min_size_reg);
        res_a.cluster_index = count_reg;
        res_a.last_cluster  = 1'b0;

        if (item_valid) begin
            if (adjacent) begin
                if (run_reg < scf_pkg::SizeCap) begin
                    run_next = run_reg + 12'd1;
                end
                if (item.sum > best_sum_reg) begin
                    best_strip_next  = item.strip_id;
                    best_sum_next    = item.sum;
                    best_sample_next = item.smax;
                end
            end else begin
                if (open_reg) begin
                    push.push_a = 1'b1;
                    if (count_reg < scf_pkg::IndexCap) begin
                        idx_after = count_reg + 11'd1;
                    end
                end
                open_next        = 1'b1;
                start_next       = item.strip_id;
                run_next         = 12'd1;
                best_strip_next  = item.strip_id;
                best_sum_next    = item.sum;
                best_sample_next = item.smax;
            end
            prev_next  = item.strip_id;
            count_next = idx_after;
            if (item.event_end) begin
                push.push_b = 1'b1;
                open_next   = 1'b0;
                count_next  = '0;
            end
        end

        res_b.first_strip   = start_next;
        res_b.cluster_size  = run_next;
        res_b.peak_strip    = best_strip_next;
        res_b.peak_sum      = best_sum_next;
        res_b.peak_sample   = best_sample_next;
        res_b.size_ok       = (run_next >= min_size_reg);
        res_b.cluster_index = idx_after;
        res_b.last_cluster  = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_size_reg    <= scf_pkg::MinSizeReset;
            open_reg        <= 1'b0;
            prev_reg        <= '0;
            start_reg       <= '0;
            run_reg         <= '0;
            best_strip_reg  <= '0;
            best_sum_reg    <= '0;
            best_sample_reg <= '0;
            count_reg       <= '0;
        end else begin
            if (cfg_write) begin
                min_size_reg <= cfg_min_size;
            end
            open_reg        <= open_next;
            prev_reg        <= prev_next;
            start_reg       <= start_next;
            run_reg         <= run_next;
            best_strip_reg  <= best_strip_next;
            best_sum_reg    <= best_sum_next;
            best_sample_reg <= best_sample_next;
            count_reg       <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/scf_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module scf_out_fifo (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire scf_pkg::push_t                push,
    input  wire scf_pkg::result_t              res_a,
    input  wire scf_pkg::result_t              res_b,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output scf_pkg::result_t                   out_res,
    output logic                               room
);

    scf_pkg::result_t              mem [scf_pkg::FifoDepth];
    logic [scf_pkg::FifoAw-1:0]    wr_reg, rd_reg;
    logic [scf_pkg::FifoCntW-1:0]  count_reg;
    logic [scf_pkg::FifoAw-1:0]    wr_next;
    logic [scf_pkg::FifoCntW-1:0]  count_next;
    logic [1:0]                    push_n;
    logic                          pop;
    scf_pkg::result_t              first_res;

    always_comb begin
        pop        = out_valid && out_ready;
        push_n     = {1'b0, push.push_a} + {1'b0, push.push_b};
        first_res  = push.push_a ? res_a : res_b;
        wr_next    = wr_reg + scf_pkg::FifoAw'(push_n);
        count_next = count_reg + scf_pkg::FifoCntW'(push_n)
                   - scf_pkg::FifoCntW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.push_a || push.push_b) begin
            mem[wr_reg] <= first_res;
        end
        if (push.push_a && push.push_b) begin
            mem[wr_reg + 3'd1] <= res_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            count_reg <= count_next;
            if (pop) begin
                rd_reg <= rd_reg + 3'd1;
            end
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_res   = mem[rd_reg];
    assign room      = (count_reg <= scf_pkg::FifoRoomMax);

endmodule

`default_nettype wire

// File: rtl/core/strip_cluster_finder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | handshake                      | payload
// ----------+-----------+--------------------------------+-------------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready  | tdata: strip + 3 samples, tlast: end
// m_axis    | out       | m_axis_tvalid / m_axis_tready  | tdata: cluster, tuser: size_ok,
//           |           |                                | tlast: last cluster of event
// cfg       | in        | cfg_valid / cfg_ready          | cfg_data: min_cluster_size
//
// One strip request per cycle while s_axis_tready is high. Sum and max are registered in the
// input stage, the cluster state updates on the next cycle and pushes 0, 1 or 2 clusters into
// an 8-deep output queue, written when the strip that closes a cluster reaches the cluster state.
// s_axis_tready drops only when the queue holds more than 4 clusters.
// Reset (aresetn low at a clock edge) closes any open cluster and empties the queue.

module strip_cluster_finder_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [11:0] strip_id, [24:12] adc_sample0, [37:25] adc_sample1, [50:38] adc_sample2
    input  wire logic [55:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [11:0] first_strip, [23:12] cluster_size, [35:24] peak_strip, [50:36] peak_sum,
    // [63:51] peak_sample, [74:64] cluster_index
    output logic [79:0]      m_axis_tdata,
    // [0] size_ok
    output logic             m_axis_tuser,
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [11:0] cfg_data
);

    logic              in_accept;
    logic              item_valid;
    scf_pkg::strip_t   item;
    scf_pkg::push_t    push;
    scf_pkg::result_t  res_a;
    scf_pkg::result_t  res_b;
    scf_pkg::result_t  out_res;
    logic              room;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = room;
    assign in_accept     = s_axis_tvalid && room;

    scf_input_stage u_input (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .in_strip   (s_axis_tdata[11:0]),
        .in_s0      (s_axis_tdata[24:12]),
        .in_s1      (s_axis_tdata[37:25]),
        .in_s2      (s_axis_tdata[50:38]),
        .in_end     (s_axis_tlast),
        .item_valid (item_valid),
        .item       (item)
    );

    scf_cluster u_cluster (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_write    (cfg_valid),
        .cfg_min_size (cfg_data),
        .item_valid   (item_valid),
        .item         (item),
        .push         (push),
        .res_a        (res_a),
        .res_b        (res_b)
    );

    scf_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .res_a     (res_a),
        .res_b     (res_b),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res),
        .room      (room)
    );

    assign m_axis_tdata = {5'd0, out_res.cluster_index, out_res.peak_sample,
                           out_res.peak_sum, out_res.peak_strip,
                           out_res.cluster_size, out_res.first_strip};
    assign m_axis_tuser = out_res.size_ok;
    assign m_axis_tlast = out_res.last_cluster;

endmodule

`default_nettype wire
